@@ rtl/core/assert_macros.svh @@
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rles_pkg.sv @@
// Types and constants of the link and estop supervisor.
package rles_pkg;

  localparam int RAW_W = 11;
  localparam int THR_W = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_HOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUBMERGED_FRESH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKSTOP        = 3'd5;

  localparam logic [RAW_W-1:0] BAND_LOW_RST  = 11'd700;
  localparam logic [RAW_W-1:0] BAND_HIGH_RST = 11'd1300;
  localparam logic [THR_W-1:0] RECOVER_HOLD_RST = 16'd50;
  localparam logic [THR_W-1:0] LATCH_TIMEOUT_RST = 16'd250;
  localparam logic [THR_W-1:0] SUBMERGED_FRESH_RST = 16'd25;
  localparam logic [THR_W-1:0] BACKSTOP_RST     = 16'd7500;

  typedef enum logic [1:0] {
    DET_UNKNOWN = 2'd0,
    DET_DOWN    = 2'd1,
    DET_MID     = 2'd2,
    DET_UP      = 2'd3
  } detent_t;

  localparam logic [1:0] MODE_SAFE   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_GUIDED = 2'd2;

  // Reported link state codes
  localparam logic [1:0] LINK_CODE_OK      = 2'd0;
  localparam logic [1:0] LINK_CODE_LOST    = 2'd1;
  localparam logic [1:0] LINK_CODE_LATCHED = 2'd2;

  typedef enum logic [2:0] {
    LS_OK      = 3'b001,
    LS_LOST    = 3'b010,
    LS_LATCHED = 3'b100
  } link_state_t;

  typedef struct packed {
    logic [RAW_W-1:0] band_low;
    logic [RAW_W-1:0] band_high;
    logic [THR_W-1:0] recover_hold_ticks;
    logic [THR_W-1:0] latch_timeout_ticks;
    logic [THR_W-1:0] submerged_fresh_ticks;
    logic [THR_W-1:0] backstop_ticks;
  } cfg_t;

  typedef struct packed {
    logic             link_up;
    logic             switch_readable;
    logic [RAW_W-1:0] switch_raw;
    logic             submerged_arrived;
    logic             submerged_value;
  } item_t;

  typedef struct packed {
    logic       link_ok;
    logic       relay_enable;
    logic [1:0] mode_cmd;
    detent_t    switch_detent;
    logic [1:0] link_state;
    logic       suppressing;
  } result_t;

endpackage

@@ rtl/core/rles_supervise.sv @@
// Supervisor state and per-tick decision logic: detent, suppression and link state machine.
module rles_supervise #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  rles_pkg::item_t   item,
  input  rles_pkg::cfg_t    cfg,
  output rles_pkg::result_t result
);

  localparam int CNT_W = TICK_COUNTER_BITS;
  localparam int CMP_W = (CNT_W > rles_pkg::THR_W) ? CNT_W : rles_pkg::THR_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  rles_pkg::link_state_t fsm_state, fsm_state_next;
  logic                  good_started;
  logic [CNT_W-1:0]      good_ticks, good_ticks_next;
  logic [CNT_W-1:0]      lost_ticks, lost_ticks_next, lost_step;
  logic                  ack_seen, ack_seen_next;
  rles_pkg::detent_t     last_live_detent, last_live_detent_next;
  logic                  submerged_flag, submerged_flag_next;
  logic                  submerged_seen, submerged_seen_next;
  logic [CNT_W-1:0]      submerged_age, submerged_age_next;
  logic                  suppress_engaged, suppress_engaged_next;
  logic [CNT_W-1:0]      suppress_held, suppress_held_next;

  rles_pkg::detent_t det, eff;
  logic              link, requested, ends, sup, stable, permit;
  logic [1:0]        mode;

  always_comb begin
    link = item.link_up;

    // Submerged message bookkeeping
    submerged_flag_next = item.submerged_arrived ? item.submerged_value : submerged_flag;
    submerged_seen_next = submerged_seen | item.submerged_arrived;
    if (item.submerged_arrived) begin
      submerged_age_next = '0;
    end else if (submerged_seen && submerged_age != CNT_MAX) begin
      submerged_age_next = submerged_age + CNT_ONE;
    end else begin
      submerged_age_next = submerged_age;
    end

    // Detent; down test wins when the band is crossed
    if (!(link && item.switch_readable)) begin
      det = rles_pkg::DET_UNKNOWN;
    end else if (item.switch_raw < cfg.band_low) begin
      det = rles_pkg::DET_DOWN;
    end else if (item.switch_raw > cfg.band_high) begin
      det = rles_pkg::DET_UP;
    end else begin
      det = rles_pkg::DET_MID;
    end
    last_live_detent_next = (link && det != rles_pkg::DET_UNKNOWN) ? det : last_live_detent;

    // Suppression
    requested = submerged_flag_next && submerged_seen_next &&
                (CMP_W'(submerged_age_next) <= CMP_W'(cfg.submerged_fresh_ticks));
    ends = !requested ||
           (link && (fsm_state == rles_pkg::LS_OK || det == rles_pkg::DET_DOWN ||
                     det == rles_pkg::DET_UNKNOWN));
    suppress_engaged_next = !ends;
    if (ends || !suppress_engaged) begin
      suppress_held_next = '0;
    end else if (suppress_held != CNT_MAX) begin
      suppress_held_next = suppress_held + CNT_ONE;
    end else begin
      suppress_held_next = suppress_held;
    end
    sup = !ends && !(cfg.backstop_ticks != '0 &&
                     CMP_W'(suppress_held_next) >= CMP_W'(cfg.backstop_ticks));

    // Tick counters; suppression re-stamps the loss
    if (sup) begin
      lost_step = '0;
    end else if (lost_ticks != CNT_MAX) begin
      lost_step = lost_ticks + CNT_ONE;
    end else begin
      lost_step = lost_ticks;
    end
    if (!link || !good_started) begin
      good_ticks_next = '0;
    end else if (good_ticks != CNT_MAX) begin
      good_ticks_next = good_ticks + CNT_ONE;
    end else begin
      good_ticks_next = good_ticks;
    end
    stable = link && (CMP_W'(good_ticks_next) >= CMP_W'(cfg.recover_hold_ticks));

    fsm_state_next  = fsm_state;
    lost_ticks_next = lost_step;
    ack_seen_next   = ack_seen;
    unique case (fsm_state)
      rles_pkg::LS_OK: begin
        if (!link) begin
          lost_ticks_next = '0;
          ack_seen_next   = 1'b0;
          fsm_state_next  = rles_pkg::LS_LOST;
        end
      end
      rles_pkg::LS_LOST: begin
        if (stable) begin
          fsm_state_next = rles_pkg::LS_OK;
        end else if (CMP_W'(lost_step) >= CMP_W'(cfg.latch_timeout_ticks)) begin
          ack_seen_next  = 1'b0;
          fsm_state_next = rles_pkg::LS_LATCHED;
        end
      end
      rles_pkg::LS_LATCHED: begin
        // Clear the latch with down, then mid, both on a live link
        ack_seen_next = ack_seen | (link && det == rles_pkg::DET_DOWN);
        if (stable && ack_seen_next && det == rles_pkg::DET_MID) begin
          fsm_state_next = rles_pkg::LS_OK;
        end
      end
      default: begin
        fsm_state_next = rles_pkg::LS_OK;
      end
    endcase

    permit = sup || (fsm_state_next == rles_pkg::LS_OK && det != rles_pkg::DET_DOWN &&
                     det != rles_pkg::DET_UNKNOWN);
    eff = sup ? last_live_detent_next : det;
    case (eff)
      rles_pkg::DET_MID: mode = rles_pkg::MODE_MANUAL;
      rles_pkg::DET_UP:  mode = rles_pkg::MODE_GUIDED;
      default:           mode = rles_pkg::MODE_SAFE;
    endcase

    result.link_ok       = link;
    result.relay_enable  = permit;
    result.mode_cmd      = mode;
    result.switch_detent = det;
    result.suppressing   = sup;
    unique case (fsm_state_next)
      rles_pkg::LS_LOST:    result.link_state = rles_pkg::LINK_CODE_LOST;
      rles_pkg::LS_LATCHED: result.link_state = rles_pkg::LINK_CODE_LATCHED;
      default:              result.link_state = rles_pkg::LINK_CODE_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state        <= rles_pkg::LS_OK;
      good_started     <= 1'b0;
      good_ticks       <= '0;
      lost_ticks       <= '0;
      ack_seen         <= 1'b0;
      last_live_detent <= rles_pkg::DET_UNKNOWN;
      submerged_flag   <= 1'b0;
      submerged_seen   <= 1'b0;
      submerged_age    <= '0;
      suppress_engaged <= 1'b0;
      suppress_held    <= '0;
    end else if (advance) begin
      fsm_state        <= fsm_state_next;
      good_started     <= link;
      good_ticks       <= good_ticks_next;
      lost_ticks       <= lost_ticks_next;
      ack_seen         <= ack_seen_next;
      last_live_detent <= last_live_detent_next;
      submerged_flag   <= submerged_flag_next;
      submerged_seen   <= submerged_seen_next;
      submerged_age    <= submerged_age_next;
      suppress_engaged <= suppress_engaged_next;
      suppress_held    <= suppress_held_next;
    end
  end

endmodule

@@ rtl/core/rc_link_estop_supervisor.sv @@
// Top level of the radio link and estop supervisor.
// One request is one poll tick; each tick gives exactly one result with the relay
// permit, mode request, switch detent and link state. A request is registered on
// entry; its state update and result are worked out by the supervisor logic and
// land in the output register once that register can take them, and a new request
// is taken every cycle while the output side keeps up. Throughput is one tick per
// clock while the output side keeps up, set by the single update of the
// supervisor state registers per tick. Tick counters are TICK_COUNTER_BITS wide
// and saturate. Configuration writes take effect at once and are meant for idle.
module rc_link_estop_supervisor #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rles_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rles_pkg::THR_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              link_up,
  input  logic                              switch_readable,
  input  logic [rles_pkg::RAW_W-1:0]        switch_raw,
  input  logic                              submerged_arrived,
  input  logic                              submerged_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              link_ok,
  output logic                              relay_enable,
  output logic [1:0]                        mode_cmd,
  output logic [1:0]                        switch_detent,
  output logic [1:0]                        link_state,
  output logic                              suppressing
);

  rles_pkg::cfg_t    cfg;
  rles_pkg::item_t   s1_item;
  logic              s1_valid;
  rles_pkg::result_t res, out_res;
  logic              load_out, advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_low              <= rles_pkg::BAND_LOW_RST;
      cfg.band_high             <= rles_pkg::BAND_HIGH_RST;
      cfg.recover_hold_ticks    <= rles_pkg::RECOVER_HOLD_RST;
      cfg.latch_timeout_ticks   <= rles_pkg::LATCH_TIMEOUT_RST;
      cfg.submerged_fresh_ticks <= rles_pkg::SUBMERGED_FRESH_RST;
      cfg.backstop_ticks        <= rles_pkg::BACKSTOP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rles_pkg::REG_BAND_LOW:        cfg.band_low  <= cfg_data[rles_pkg::RAW_W-1:0];
        rles_pkg::REG_BAND_HIGH:       cfg.band_high <= cfg_data[rles_pkg::RAW_W-1:0];
        rles_pkg::REG_RECOVER_HOLD:    cfg.recover_hold_ticks    <= cfg_data;
        rles_pkg::REG_LATCH_TIMEOUT:   cfg.latch_timeout_ticks   <= cfg_data;
        rles_pkg::REG_SUBMERGED_FRESH: cfg.submerged_fresh_ticks <= cfg_data;
        rles_pkg::REG_BACKSTOP:        cfg.backstop_ticks        <= cfg_data;
        default: begin
          // Drop writes beyond the register list
        end
      endcase
    end
  end

  assign load_out = !out_valid || out_ready;
  assign advance  = s1_valid && load_out;
  assign in_ready = !s1_valid || load_out;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.link_up           <= link_up;
      s1_item.switch_readable   <= switch_readable;
      s1_item.switch_raw        <= switch_raw;
      s1_item.submerged_arrived <= submerged_arrived;
      s1_item.submerged_value   <= submerged_value;
    end
  end

  rles_supervise #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_supervise (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign link_ok       = out_res.link_ok;
  assign relay_enable  = out_res.relay_enable;
  assign mode_cmd      = out_res.mode_cmd;
  assign switch_detent = out_res.switch_detent;
  assign link_state    = out_res.link_state;
  assign suppressing   = out_res.suppressing;

`include "assert_macros.svh"

  `CHECK_NEXT(a_accept_fills_stage, in_valid && in_ready, s1_valid, "accepted request lost")
  `CHECK_IMPL(a_latched_no_permit,
              out_valid && link_state == rles_pkg::LINK_CODE_LATCHED && !suppressing,
              !relay_enable, "permit while latched")
  `CHECK_IMPL(a_suppress_permits, out_valid && suppressing, relay_enable,
              "suppression without permit")
  `CHECK_IMPL(a_no_link_not_ok, out_valid && !link_ok,
              link_state != rles_pkg::LINK_CODE_OK, "link state ok without link")

endmodule

@@ tb/sv/rc_link_estop_supervisor_checker.sv @@
// Checker that predicts and compares the supervisor results per poll tick.
module rc_link_estop_supervisor_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rles_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rles_pkg::THR_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           link_up,
  input  logic                           switch_readable,
  input  logic [rles_pkg::RAW_W-1:0]     switch_raw,
  input  logic                           submerged_arrived,
  input  logic                           submerged_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           link_ok,
  input  logic                           relay_enable,
  input  logic [1:0]                     mode_cmd,
  input  logic [1:0]                     switch_detent,
  input  logic [1:0]                     link_state,
  input  logic                           suppressing,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int TICK_W = 16;

  // settings
  logic [rles_pkg::RAW_W-1:0] band_low, band_high;
  logic [rles_pkg::THR_W-1:0] hold_need, latch_need, fresh_limit, backstop_limit;

  // supervisor state
  logic [1:0]        link_code;
  logic              good_run;
  logic [TICK_W-1:0] good_count, lost_count;
  logic              ack_down;
  rles_pkg::detent_t live_detent;
  logic              sub_flag, sub_seen;
  logic [TICK_W-1:0] sub_age;
  logic              sup_engaged;
  logic [TICK_W-1:0] sup_held;

  rles_pkg::result_t pending_verdicts[$];
  rles_pkg::result_t want, fresh_verdict;
  int                bad_count;

  initial begin
    bad_count = 0;
  end

  function automatic logic [TICK_W-1:0] tick_up(input logic [TICK_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic supervise_tick(input logic lk, input logic rd,
                                input logic [rles_pkg::RAW_W-1:0] raw,
                                input logic arr, input logic val,
                                output rles_pkg::result_t verdict);
    rles_pkg::detent_t det, shown;
    logic    holding, stable, fresh, ends;
    if (arr) begin
      sub_flag = val;
      sub_seen = 1'b1;
      sub_age = '0;
    end else if (sub_seen) begin
      sub_age = tick_up(sub_age);
    end

    det = rles_pkg::DET_UNKNOWN;
    if (lk && rd) begin
      if (raw < band_low) det = rles_pkg::DET_DOWN;
      else if (raw > band_high) det = rles_pkg::DET_UP;
      else det = rles_pkg::DET_MID;
    end
    if (lk && det != rles_pkg::DET_UNKNOWN) live_detent = det;

    // suppression is decided on the link state from before this tick
    fresh = sub_flag && sub_seen && (sub_age <= fresh_limit);
    ends = !fresh || (lk && link_code == rles_pkg::LINK_CODE_OK) ||
           (lk && det == rles_pkg::DET_DOWN) || (lk && det == rles_pkg::DET_UNKNOWN);
    if (ends) begin
      sup_engaged = 1'b0;
      sup_held = '0;
      holding = 1'b0;
    end else begin
      if (!sup_engaged) begin
        sup_engaged = 1'b1;
        sup_held = '0;
      end else begin
        sup_held = tick_up(sup_held);
      end
      holding = !(backstop_limit != '0 && sup_held >= backstop_limit);
    end

    lost_count = tick_up(lost_count);
    if (holding) lost_count = '0;
    if (lk) begin
      if (!good_run) begin
        good_run = 1'b1;
        good_count = '0;
      end else begin
        good_count = tick_up(good_count);
      end
    end else begin
      good_run = 1'b0;
      good_count = '0;
    end
    stable = good_run && (good_count >= hold_need);

    case (link_code)
      rles_pkg::LINK_CODE_OK: begin
        if (!lk) begin
          lost_count = '0;
          ack_down = 1'b0;
          link_code = rles_pkg::LINK_CODE_LOST;
        end
      end
      rles_pkg::LINK_CODE_LOST: begin
        if (stable) begin
          link_code = rles_pkg::LINK_CODE_OK;
        end else if (lost_count >= latch_need) begin
          ack_down = 1'b0;
          link_code = rles_pkg::LINK_CODE_LATCHED;
        end
      end
      default: begin
        if (lk && det == rles_pkg::DET_DOWN) ack_down = 1'b1;
        if (stable && ack_down && det == rles_pkg::DET_MID) link_code = rles_pkg::LINK_CODE_OK;
      end
    endcase

    shown = holding ? live_detent : det;
    verdict.link_ok = lk;
    verdict.relay_enable = holding ? 1'b1 :
        (link_code == rles_pkg::LINK_CODE_OK && det != rles_pkg::DET_DOWN &&
         det != rles_pkg::DET_UNKNOWN);
    case (shown)
      rles_pkg::DET_MID: verdict.mode_cmd = rles_pkg::MODE_MANUAL;
      rles_pkg::DET_UP:  verdict.mode_cmd = rles_pkg::MODE_GUIDED;
      default:           verdict.mode_cmd = rles_pkg::MODE_SAFE;
    endcase
    verdict.switch_detent = det;
    verdict.link_state = link_code;
    verdict.suppressing = holding;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      band_low = rles_pkg::BAND_LOW_RST;
      band_high = rles_pkg::BAND_HIGH_RST;
      hold_need = rles_pkg::RECOVER_HOLD_RST;
      latch_need = rles_pkg::LATCH_TIMEOUT_RST;
      fresh_limit = rles_pkg::SUBMERGED_FRESH_RST;
      backstop_limit = rles_pkg::BACKSTOP_RST;
      link_code = rles_pkg::LINK_CODE_OK;
      good_run = 1'b0;
      good_count = '0;
      lost_count = '0;
      ack_down = 1'b0;
      live_detent = rles_pkg::DET_UNKNOWN;
      sub_flag = 1'b0;
      sub_seen = 1'b0;
      sub_age = '0;
      sup_engaged = 1'b0;
      sup_held = '0;
      pending_verdicts.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rles_pkg::REG_BAND_LOW:        band_low = cfg_data[rles_pkg::RAW_W-1:0];
          rles_pkg::REG_BAND_HIGH:       band_high = cfg_data[rles_pkg::RAW_W-1:0];
          rles_pkg::REG_RECOVER_HOLD:    hold_need = cfg_data;
          rles_pkg::REG_LATCH_TIMEOUT:   latch_need = cfg_data;
          rles_pkg::REG_SUBMERGED_FRESH: fresh_limit = cfg_data;
          rles_pkg::REG_BACKSTOP:        backstop_limit = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("result with no request pending");
        end else begin
          want = pending_verdicts.pop_front();
          if (link_ok !== want.link_ok || relay_enable !== want.relay_enable ||
              mode_cmd !== want.mode_cmd ||
              switch_detent !== want.switch_detent ||
              link_state !== want.link_state || suppressing !== want.suppressing) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("mismatch: want link=%0d permit=%0d mode=%0d det=%0d st=%0d sup=%0d",
                       want.link_ok, want.relay_enable, want.mode_cmd,
                       want.switch_detent, want.link_state, want.suppressing);
              $display("          got  link=%0d permit=%0d mode=%0d det=%0d st=%0d sup=%0d",
                       link_ok, relay_enable, mode_cmd, switch_detent,
                       link_state, suppressing);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        supervise_tick(link_up, switch_readable, switch_raw, submerged_arrived,
                       submerged_value, fresh_verdict);
        pending_verdicts.push_back(fresh_verdict);
      end
    end
    mismatches <= bad_count;
    outstanding <= pending_verdicts.size();
  end

endmodule

@@ tb/sv/rc_link_estop_supervisor_tb.sv @@
// Testbench top: drives poll requests and settings, gives the verdict.
module rc_link_estop_supervisor_tb;

  localparam int TICKS_PER_PHASE = 105;
  localparam int HOLD_OFF_AT = 300;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RUN_CAP = 20;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [rles_pkg::CFG_IDX_W-1:0] cfg_index = rles_pkg::REG_BAND_LOW;
  logic [rles_pkg::THR_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           link_up = 1'b0;
  logic                           switch_readable = 1'b0;
  logic [rles_pkg::RAW_W-1:0]     switch_raw = '0;
  logic                           submerged_arrived = 1'b0;
  logic                           submerged_value = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           link_ok;
  logic                           relay_enable;
  logic [1:0]                     mode_cmd;
  logic [1:0]                     switch_detent;
  logic [1:0]                     link_state;
  logic                           suppressing;
  int                             mismatches;
  int                             outstanding;

  // shaping of the random poll sequences
  logic [rles_pkg::RAW_W-1:0]     band_low = rles_pkg::BAND_LOW_RST;
  logic [rles_pkg::RAW_W-1:0]     band_high = rles_pkg::BAND_HIGH_RST;
  int                             hold_len = RUN_CAP;
  int                             latch_len = RUN_CAP;
  logic                           link_lvl = 1'b1;
  int                             link_left = 0;
  int                             sw_left = 0;
  logic [rles_pkg::RAW_W-1:0]     raw_now = 11'd1024;
  logic                           read_now = 1'b1;

  rc_link_estop_supervisor uut (.*);

  rc_link_estop_supervisor_checker watch (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_tick(input logic lk, input logic rd,
                           input logic [rles_pkg::RAW_W-1:0] raw,
                           input logic arr, input logic val, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : int'($urandom_range(0, 15));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    link_up <= lk;
    switch_readable <= rd;
    switch_raw <= raw;
    submerged_arrived <= arr;
    submerged_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the last accepted request reach the output, then settle
  task automatic drain();
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [rles_pkg::RAW_W-1:0] lo,
                               input logic [rles_pkg::RAW_W-1:0] hi,
                               input logic [rles_pkg::THR_W-1:0] rec,
                               input logic [rles_pkg::THR_W-1:0] lat,
                               input logic [rles_pkg::THR_W-1:0] fr,
                               input logic [rles_pkg::THR_W-1:0] bs);
    drain();
    band_low = lo;
    band_high = hi;
    hold_len = (rec > RUN_CAP) ? RUN_CAP : int'(rec);
    latch_len = (lat > RUN_CAP) ? RUN_CAP : int'(lat);
    cfg_write <= 1'b1;
    cfg_index <= rles_pkg::REG_BAND_LOW;
    cfg_data <= {5'($urandom), lo};
    @(posedge clk);
    cfg_index <= rles_pkg::REG_BAND_HIGH;
    cfg_data <= {5'($urandom), hi};
    @(posedge clk);
    cfg_index <= rles_pkg::REG_RECOVER_HOLD;
    cfg_data <= rec;
    @(posedge clk);
    cfg_index <= rles_pkg::REG_LATCH_TIMEOUT;
    cfg_data <= lat;
    @(posedge clk);
    cfg_index <= rles_pkg::REG_SUBMERGED_FRESH;
    cfg_data <= fr;
    @(posedge clk);
    cfg_index <= rles_pkg::REG_BACKSTOP;
    cfg_data <= bs;
    @(posedge clk);
    // unmapped index, must be dropped
    cfg_index <= rles_pkg::REG_BACKSTOP + 3'($urandom_range(1, 2));
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    int   k;
    bit   steady;
    logic lk;
    for (k = 0; k < count; k++) begin
      if (k % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      // link in runs of random length, bounded by the capped recover and latch settings
      if (link_left == 0) begin
        link_lvl = !link_lvl;
        link_left = link_lvl ? int'($urandom_range(1, hold_len * 3 + 4))
                             : int'($urandom_range(1, latch_len * 2 + 3));
      end
      link_left--;
      if (sw_left == 0) begin
        case ($urandom_range(0, 3))
          0: raw_now = (band_low > 0) ? 11'($urandom_range(0, band_low - 1)) : 11'd0;
          1: raw_now = (band_high < 11'd2047) ?
                       11'($urandom_range(band_high + 1, 2047)) : 11'd2047;
          2: raw_now = 11'($urandom_range(band_low, band_high));
          default: raw_now = 11'($urandom_range(0, 2047));
        endcase
        read_now = ($urandom_range(0, 15) != 0);
        sw_left = int'($urandom_range(1, 12));
      end
      sw_left--;
      lk = link_lvl;
      if ($urandom_range(0, 7) == 0) lk = 1'($urandom_range(0, 1));
      send_tick(lk, read_now, raw_now, ($urandom_range(0, 11) == 0),
                ($urandom_range(0, 3) != 0), steady);
    end
    in_valid <= 1'b0;
  endtask

  // result side: random stalls, stall-free stretches, one long hold-off
  initial begin : drain_results
    int stall;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      else if ((taken / 64) % 3 == 0) stall = 0;
      else stall = int'($urandom_range(0, 15));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: band edges, raw extremes, unreadable switch, suppression
    send_tick(1'b1, 1'b1, 11'd0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 11'd2047, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 11'd699, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 11'd700, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 11'd1300, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 11'd1301, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 11'h555, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 11'h2AA, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 11'd1024, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 11'd1024, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 11'd1024, 1'b1, 1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b1, 11'd1024, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 11'd0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 11'd0, 1'b1, 1'b0, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1, 11'd1024, 1'b0, 1'b1, 1'b0);
    repeat (2) send_tick(1'b1, 1'b1, 11'd1024, 1'b0, 1'b0, 1'b0);
    in_valid <= 1'b0;

    load_settings(11'($urandom_range(400, 1000)), 11'($urandom_range(1000, 1600)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 10)));
    run_phase(TICKS_PER_PHASE);

    load_settings('0, '0, '0, '0, '0, '0);
    run_phase(TICKS_PER_PHASE);

    load_settings(11'd2047, 11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(TICKS_PER_PHASE);

    // crossed band
    load_settings(11'd1500, 11'd500, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(1, 10)));
    run_phase(TICKS_PER_PHASE);

    // no backstop, long freshness
    load_settings(11'($urandom_range(400, 1000)), 11'($urandom_range(1000, 1600)),
                  16'($urandom_range(0, 10)), 16'($urandom_range(0, 20)),
                  16'($urandom_range(10, 30)), '0);
    run_phase(TICKS_PER_PHASE);

    load_settings(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
    run_phase(TICKS_PER_PHASE);

    load_settings(11'($urandom_range(400, 1000)), 11'($urandom_range(1000, 1600)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 10)));
    run_phase(TICKS_PER_PHASE);

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
